/* hw/rtl/bpa_pkg.sv */
// shared types and constants for the bitmap page allocator
// no dependencies; imported by the interfaces and all allocator modules
package bpa_pkg;

  // parameter defaults
  localparam int DEF_MAX_PAGES  = 32768;
  localparam int DEF_PAGE_BYTES = 4096;

  // bitmap memory word geometry
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // register and field widths
  localparam int CFG_W    = 16;
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;

  // request kinds
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic clear;       // write one all-ones word of the clearing pass
    logic load;        // capture the accepted request
    logic rmw;         // modify and write back the word read for free / reserve
    logic scan;        // one step of the allocation scan
    logic range_fail;  // record an out-of-range or unknown request
    logic out_load;    // move the result into the output register
  } bpa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            in_range;
    logic            found;
    logic            exhausted;
    logic            out_free;
  } bpa_sts_t;

endpackage

/* hw/rtl/bpa_req_if.sv */
// request channel interface: valid / ready with op and addr
// depends on bpa_pkg
interface bpa_req_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] addr;

  modport source (output valid, output op, output addr, input ready);
  modport sink (input valid, input op, input addr, output ready);
endinterface

/* hw/rtl/bpa_rsp_if.sv */
// result channel interface: valid / ready with page_addr and status
// depends on bpa_pkg
interface bpa_rsp_if;
  import bpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   page_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output page_addr, output status, input ready);
  modport sink (input valid, input page_addr, input status, output ready);
endinterface

/* hw/rtl/bpa_ctrl.sv */
// controller state machine of the bitmap page allocator
// depends on bpa_pkg; drives bpa_datapath through bpa_cmd_t
module bpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  import bpa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == OP_ALLOC) begin
          state_nxt = S_SCAN;
        end else if ((sts.op == OP_FREE || sts.op == OP_RESERVE) && sts.in_range) begin
          state_nxt = S_RMW;
        end else begin
          cmd.range_fail = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_RMW: begin
        cmd.rmw   = 1'b1;
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.exhausted) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/bpa_datapath.sv */
// datapath of the bitmap page allocator: bitmap memory, scan counters,
// page_count register, result and output registers; depends on bpa_pkg
module bpa_datapath #(
  parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bpa_pkg::OP_W-1:0]       in_op,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_addr,
  input  logic                           cfg_wr_en,
  input  logic [bpa_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [bpa_pkg::ADDR_W-1:0]     out_page_addr,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  input  bpa_pkg::bpa_cmd_t              cmd,
  output bpa_pkg::bpa_sts_t              sts
);
  import bpa_pkg::*;

  localparam int WORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WCNT_W     = $clog2(WORDS + 1);
  localparam int CMP_W      = WCNT_W + WORD_SHIFT;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // bitmap store, one bit per page, set means used
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [WADDR_W-1:0]   raddr;
  logic [WADDR_W-1:0]   waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;

  logic [CFG_W-1:0]      page_count_r;
  logic [CMP_W-1:0]      limit;
  logic [WADDR_W-1:0]    clr_ptr_r;

  logic [OP_W-1:0]       op_r;
  logic [WADDR_W-1:0]    wrd_r;
  logic [WORD_SHIFT-1:0] bit_r;
  logic                  in_range_r;
  logic [ADDR_W-1:0]     in_page;

  logic [WCNT_W-1:0]     rd_word_r;
  logic [WCNT_W-1:0]     chk_word_r;
  logic                  chk_vld_r;
  logic                  scan_started_r;
  logic [CMP_W:0]        lim_up;
  logic                  rd_ok;

  logic [CMP_W-1:0]      base;
  logic [CMP_W-1:0]      rem;
  logic [WORD_SHIFT:0]   rem_sat;
  logic [WORD_BITS-1:0]  beyond;
  logic [WORD_BITS-1:0]  free_vec;
  logic [WORD_SHIFT-1:0] free_idx;
  logic                  found;
  logic [CMP_W-1:0]      page_num;
  logic [63:0]           page_wide;
  logic                  cur_bit;

  logic [ADDR_W-1:0]     res_addr_r;
  logic [STATUS_W-1:0]   res_status_r;
  logic                  out_valid_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [STATUS_W-1:0]   out_status_r;

  // active limit, saturated to the store size
  always_comb begin
    if (32'(page_count_r) > 32'(MAX_PAGES)) begin
      limit = CMP_W'(MAX_PAGES);
    end else begin
      limit = CMP_W'(page_count_r);
    end
  end

  assign in_page = in_addr >> PAGE_SHIFT;

  // scan bookkeeping: word still below the limit, bits beyond the limit
  assign lim_up  = {1'b0, limit} + (CMP_W + 1)'(WORD_BITS - 1);
  assign rd_ok   = {1'b0, rd_word_r} < lim_up[CMP_W:WORD_SHIFT];
  assign base    = {chk_word_r, {WORD_SHIFT{1'b0}}};
  assign rem     = limit - base;
  assign rem_sat = (rem >= CMP_W'(WORD_BITS)) ? (WORD_SHIFT + 1)'(WORD_BITS)
                                              : rem[WORD_SHIFT:0];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      beyond[i] = (WORD_SHIFT + 1)'(i) >= rem_sat;
    end
  end

  assign free_vec = ~(rdata_r | beyond);
  assign found    = chk_vld_r && (|free_vec);

  // lowest free bit
  always_comb begin
    free_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = WORD_SHIFT'(i);
      end
    end
  end

  assign page_num  = {chk_word_r, free_idx};
  assign page_wide = 64'(page_num) << PAGE_SHIFT;
  assign cur_bit   = rdata_r[bit_r];

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = wrd_r;
    wdata = rdata_r;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_ptr_r;
      wdata = '1;
    end else if (cmd.rmw) begin
      waddr = wrd_r;
      if (op_r == OP_FREE) begin
        we    = cur_bit;
        wdata = rdata_r & ~(WORD_BITS'(1) << bit_r);
      end else begin
        we    = 1'b1;
        wdata = rdata_r | (WORD_BITS'(1) << bit_r);
      end
    end else if (cmd.scan && found) begin
      we    = 1'b1;
      waddr = chk_word_r[WADDR_W-1:0];
      wdata = rdata_r | (WORD_BITS'(1) << free_idx);
    end
  end

  assign raddr = cmd.scan ? rd_word_r[WADDR_W-1:0] : wrd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r   <= '0;
      clr_ptr_r      <= '0;
      chk_vld_r      <= 1'b0;
      scan_started_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        page_count_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        clr_ptr_r <= clr_ptr_r + WADDR_W'(1);
      end
      if (cmd.load) begin
        chk_vld_r      <= 1'b0;
        scan_started_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_vld_r      <= rd_ok;
        scan_started_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      wrd_r      <= in_page[WORD_SHIFT +: WADDR_W];
      bit_r      <= in_page[WORD_SHIFT-1:0];
      in_range_r <= in_page < ADDR_W'(limit);
      rd_word_r  <= '0;
    end else if (cmd.scan) begin
      rd_word_r  <= rd_word_r + WCNT_W'(1);
      chk_word_r <= rd_word_r;
    end
    if (cmd.range_fail) begin
      res_addr_r   <= '0;
      res_status_r <= ST_RANGE;
    end else if (cmd.rmw) begin
      res_addr_r   <= '0;
      res_status_r <= (op_r == OP_FREE && !cur_bit) ? ST_ALREADY_FREE : ST_DONE;
    end else if (cmd.scan && found) begin
      res_addr_r   <= page_wide[ADDR_W-1:0];
      res_status_r <= ST_DONE;
    end else if (cmd.scan && scan_started_r && !chk_vld_r) begin
      res_addr_r   <= '0;
      res_status_r <= ST_NO_FREE;
    end
    if (cmd.out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.clr_last  = clr_ptr_r == WADDR_W'(WORDS - 1);
  assign sts.op        = op_r;
  assign sts.in_range  = in_range_r;
  assign sts.found     = found;
  assign sts.exhausted = scan_started_r && !chk_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_page_addr = out_addr_r;
  assign out_status    = out_status_r;

endmodule

/* hw/rtl/bitmap_page_allocator.sv */
// bitmap page allocator top level: one transaction in flight, one result per request
// a bad request is rejected after the check, a free / reserve does one read-modify-write,
//   an allocate scans the 32-page words upward from word 0 to the first free page or the limit
// the next request is taken only once the output register loads
// reset: synchronous, active low, then a clearing pass sets each bitmap word to all used,
//   one word per cycle (MAX_PAGES / 32 = 1024 words by default), no requests taken meanwhile
module bitmap_page_allocator #(
  parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bpa_pkg::CFG_W-1:0] cfg_wr_data,
  bpa_req_if.sink                   in_req,
  bpa_rsp_if.source                 out_rsp
);
  import bpa_pkg::*;

  // command and status between controller and datapath
  bpa_cmd_t cmd;
  bpa_sts_t sts;
  logic     in_ready;

  // sequencing: clear pass, request capture, read-modify-write, scan, output
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bitmap memory, page_count register and result path
  bpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_req.op),
    .in_addr       (in_req.addr),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_ready     (out_rsp.ready),
    .out_valid     (out_rsp.valid),
    .out_page_addr (out_rsp.page_addr),
    .out_status    (out_rsp.status),
    .cmd           (cmd),
    .sts           (sts)
  );

  // request channel is ready only while the controller idles
  assign in_req.ready = in_ready;

`ifndef ASSERT_OFF
  // one request at a time: ready drops right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  // the controller issues at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.load, cmd.rmw, cmd.scan, cmd.range_fail, cmd.out_load}))
    else $error("conflicting datapath commands");

  // no request is taken during the clearing pass
  a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_req.ready)
    else $error("request channel ready during clearing pass");

  // only a successful allocation carries a nonzero page address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status != ST_DONE |-> out_rsp.page_addr == '0)
    else $error("nonzero page address on a failed request");
`endif

endmodule
